### rtl/acpu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acpu_pkg
// Shared types and codes of the accumulator processor core: operation
// codes of the request channel, instruction opcodes and the result record.
// ----------------------------------------------------------------------------
package acpu_pkg;

   // request operations
   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_STEP   = 2'd1;
   localparam logic [1:0] OP_SWITCH = 2'd2;

   // instruction opcodes
   localparam logic [31:0] OPC_ACC_FROM_OPD = 32'd1;
   localparam logic [31:0] OPC_ACC_FROM_BUF = 32'd2;
   localparam logic [31:0] OPC_ACC_FROM_MAR = 32'd3;
   localparam logic [31:0] OPC_BUF_FROM_ACC = 32'd4;
   localparam logic [31:0] OPC_MAR_FROM_ACC = 32'd5;
   localparam logic [31:0] OPC_MEM_READ     = 32'd6;
   localparam logic [31:0] OPC_MEM_WRITE    = 32'd7;
   localparam logic [31:0] OPC_ADD          = 32'd8;
   localparam logic [31:0] OPC_MUL          = 32'd9;
   localparam logic [31:0] OPC_AND          = 32'd10;
   localparam logic [31:0] OPC_OR           = 32'd11;
   localparam logic [31:0] OPC_JNZ          = 32'd12;

   typedef struct packed {
      logic        running;
      logic [31:0] accumulator;
      logic [31:0] buffer;
      logic [31:0] data_address;
      logic [31:0] counter;
      logic [31:0] base;
      logic [31:0] opcode;
      logic [31:0] operand;
   } rsp_type;

endpackage

### rtl/acpu_rsp_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acpu_rsp_fifo
// Two-entry result queue. Decouples the core from a stalled receiver so
// that a new request can be taken while a finished result waits.
// ----------------------------------------------------------------------------
module acpu_rsp_fifo import acpu_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   input  logic    pop,
   output logic    out_valid,
   output rsp_type out_data,
   output logic    room
);

   rsp_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign out_valid = (count_ff != 2'd0);
   assign room      = (count_ff != 2'd2);
   assign out_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (room || pop))
      else $error("result queue overflow");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result queue count out of range");

   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd1) |-> (wr_ptr_ff != rd_ptr_ff))
      else $error("result queue pointers disagree with count");

endmodule

### rtl/accumulator_cpu_core_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accumulator_cpu_core_top
// Accumulator processor with a local entry memory (first/second word).
// ----------------------------------------------------------------------------
// Usage:
//   Requests (req_*) carry one of: load an entry, run one instruction step,
//   or switch register sets. Every request gives exactly one result on the
//   rsp_* channel, in order.
//   Load, switch and unknown operations give their result from the idle
//   state; a step first reads the fetch word, then executes, and a memory
//   read instruction needs a second access to the single-port entry
//   memory. No new request is taken until a step has finished.
//   Results pass through a two-entry queue: a request is taken while a
//   result still waits. When the queue is full the core holds the finished
//   step and stops taking requests until the receiver drains it.
//   After reset the entry memory is cleared, one entry per cycle;
//   req_ready stays low during that pass. All processor registers
//   reset to zero.
// ----------------------------------------------------------------------------
module accumulator_cpu_core_top import acpu_pkg::*; #(
   parameter int MEM_ENTRIES = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_operation,
   input  logic [7:0]         req_entry_address,
   input  logic signed [31:0] req_entry_first,
   input  logic signed [31:0] req_entry_second,
   input  logic signed [31:0] req_new_accumulator,
   input  logic signed [31:0] req_new_buffer,
   input  logic signed [31:0] req_new_data_address,
   input  logic signed [31:0] req_new_counter,
   input  logic signed [31:0] req_new_base,
   input  logic signed [31:0] req_new_opcode,
   input  logic signed [31:0] req_new_operand,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_running,
   output logic signed [31:0] rsp_accumulator,
   output logic signed [31:0] rsp_buffer,
   output logic signed [31:0] rsp_data_address,
   output logic signed [31:0] rsp_counter,
   output logic signed [31:0] rsp_base,
   output logic signed [31:0] rsp_opcode,
   output logic signed [31:0] rsp_operand
);

   localparam int              AW        = (MEM_ENTRIES > 1) ? $clog2(MEM_ENTRIES) : 1;
   localparam logic [31:0]     MEM_LIMIT = 32'(MEM_ENTRIES);
   localparam logic [AW-1:0]   LAST_IDX  = AW'(MEM_ENTRIES - 1);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_EXEC  = 2'd2;
   localparam logic [1:0] S_LOAD6 = 2'd3;

   function automatic logic addr_ok(input logic [31:0] a);
      return !a[31] && (a < MEM_LIMIT);
   endfunction

   // entry memory: [63:32] first word, [31:0] second word
   logic [63:0]   mem [0:MEM_ENTRIES-1];
   logic [63:0]   rdata_ff;
   logic          mem_we, mem_re;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [63:0]   mem_wdata;

   logic [1:0]    state_ff, state_in;
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic          fetch_ok_ff, fetch_ok_in;

   logic [31:0] acc_ff, acc_in;
   logic [31:0] buf_ff, buf_in;
   logic [31:0] mar_ff, mar_in;
   logic [31:0] cnt_ff, cnt_in;
   logic [31:0] base_ff, base_in;
   logic [31:0] opc_ff, opc_in;
   logic [31:0] opd_ff, opd_in;

   logic        req_fire, rsp_pop, push, room, rpt_new;
   rsp_type     push_data, out_data;
   logic [31:0] fetch_addr, dec_opc, dec_opd, mul_res, cnt_base;
   logic        fetch_ok, mar_ok, ea_ok;

   assign req_ready  = (state_ff == S_IDLE) && room;
   assign req_fire   = req_valid && req_ready;
   assign rsp_pop    = rsp_valid && rsp_ready;

   assign fetch_addr = base_ff + cnt_ff;
   assign fetch_ok   = addr_ok(fetch_addr);
   assign mar_ok     = addr_ok(mar_ff);
   assign ea_ok      = {24'd0, req_entry_address} < MEM_LIMIT;

   // a failed fetch clears the opcode and keeps the operand
   assign dec_opc = fetch_ok_ff ? rdata_ff[63:32] : 32'd0;
   assign dec_opd = fetch_ok_ff ? rdata_ff[31:0] : opd_ff;
   assign mul_res = acc_ff * buf_ff;

   always_comb begin
      state_in    = state_ff;
      clr_cnt_in  = clr_cnt_ff;
      fetch_ok_in = fetch_ok_ff;
      acc_in      = acc_ff;
      buf_in      = buf_ff;
      mar_in      = mar_ff;
      cnt_in      = cnt_ff;
      base_in     = base_ff;
      opc_in      = opc_ff;
      opd_in      = opd_ff;
      mem_we      = 1'b0;
      mem_waddr   = clr_cnt_ff;
      mem_wdata   = 64'd0;
      mem_re      = 1'b0;
      mem_raddr   = AW'(fetch_addr);
      push        = 1'b0;
      rpt_new     = 1'b0;
      cnt_base    = cnt_ff;

      case (state_ff)
         S_CLEAR: begin
            mem_we     = 1'b1;
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               case (req_operation)
                  OP_LOAD: begin
                     mem_we    = ea_ok;
                     mem_waddr = AW'(req_entry_address);
                     mem_wdata = {req_entry_first, req_entry_second};
                     push      = 1'b1;
                  end
                  OP_STEP: begin
                     mem_re      = fetch_ok;
                     fetch_ok_in = fetch_ok;
                     state_in    = S_EXEC;
                  end
                  OP_SWITCH: begin
                     push    = 1'b1;
                     acc_in  = req_new_accumulator;
                     buf_in  = req_new_buffer;
                     mar_in  = req_new_data_address;
                     cnt_in  = req_new_counter;
                     base_in = req_new_base;
                     opc_in  = req_new_opcode;
                     opd_in  = req_new_operand;
                  end
                  default: begin
                     push = 1'b1;
                  end
               endcase
            end
         end
         S_EXEC: begin
            if (dec_opc == OPC_MEM_READ && mar_ok) begin
               // second access: data word at mar, finished in S_LOAD6
               opc_in    = dec_opc;
               opd_in    = dec_opd;
               mem_re    = 1'b1;
               mem_raddr = AW'(mar_ff);
               state_in  = S_LOAD6;
            end else if (room) begin
               opc_in = dec_opc;
               opd_in = dec_opd;
               case (dec_opc)
                  OPC_ACC_FROM_OPD: acc_in = dec_opd;
                  OPC_ACC_FROM_BUF: acc_in = buf_ff;
                  OPC_ACC_FROM_MAR: acc_in = mar_ff;
                  OPC_BUF_FROM_ACC: buf_in = acc_ff;
                  OPC_MAR_FROM_ACC: mar_in = acc_ff;
                  OPC_MEM_READ:     opc_in = 32'd0;  // bad data address
                  OPC_MEM_WRITE: begin
                     if (mar_ok) begin
                        mem_we    = 1'b1;
                        mem_waddr = AW'(mar_ff);
                        mem_wdata = {buf_ff, 32'd0};
                     end else begin
                        opc_in = 32'd0;
                     end
                  end
                  OPC_ADD: acc_in = acc_ff + buf_ff;
                  OPC_MUL: acc_in = mul_res;
                  OPC_AND: acc_in = {31'd0, (acc_ff != 32'd0) && (buf_ff != 32'd0)};
                  OPC_OR:  acc_in = {31'd0, (acc_ff != 32'd0) || (buf_ff != 32'd0)};
                  OPC_JNZ: begin
                     if (acc_ff != 32'd0) begin
                        cnt_base = dec_opd - 32'd1;
                     end
                  end
                  default: ;
               endcase
               cnt_in   = cnt_base + 32'd1;
               push     = 1'b1;
               rpt_new  = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_LOAD6: begin
            if (room) begin
               buf_in   = rdata_ff[63:32];
               cnt_in   = cnt_ff + 32'd1;
               push     = 1'b1;
               rpt_new  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (rpt_new) begin
         push_data = '{opc_in != 32'd0, acc_in, buf_in, mar_in, cnt_in, base_in,
                       opc_in, opd_in};
      end else begin
         push_data = '{opc_ff != 32'd0, acc_ff, buf_ff, mar_ff, cnt_ff, base_ff,
                       opc_ff, opd_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         clr_cnt_ff  <= '0;
         fetch_ok_ff <= 1'b0;
         acc_ff      <= 32'd0;
         buf_ff      <= 32'd0;
         mar_ff      <= 32'd0;
         cnt_ff      <= 32'd0;
         base_ff     <= 32'd0;
         opc_ff      <= 32'd0;
         opd_ff      <= 32'd0;
      end else begin
         state_ff    <= state_in;
         clr_cnt_ff  <= clr_cnt_in;
         fetch_ok_ff <= fetch_ok_in;
         acc_ff      <= acc_in;
         buf_ff      <= buf_in;
         mar_ff      <= mar_in;
         cnt_ff      <= cnt_in;
         base_ff     <= base_in;
         opc_ff      <= opc_in;
         opd_ff      <= opd_in;
      end
   end

   acpu_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (rsp_pop),
      .out_valid (rsp_valid),
      .out_data  (out_data),
      .room      (room)
   );

   assign rsp_running      = out_data.running;
   assign rsp_accumulator  = out_data.accumulator;
   assign rsp_buffer       = out_data.buffer;
   assign rsp_data_address = out_data.data_address;
   assign rsp_counter      = out_data.counter;
   assign rsp_base         = out_data.base;
   assign rsp_opcode       = out_data.opcode;
   assign rsp_operand      = out_data.operand;

   a_port_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("entry memory read and write in the same cycle");

   a_load6_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOAD6) |-> ($past(state_ff) == S_EXEC || $past(state_ff) == S_LOAD6))
      else $error("data read phase entered without execute phase");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> room)
      else $error("result pushed into a full queue");

   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !push && !mem_re)
      else $error("activity during memory clearing pass");

endmodule

### tb/accumulator_cpu_core_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accumulator_cpu_core_top_tb
// Self-checking bench for the accumulator processor core. A shadow copy of
// the core (registers and entry memory) predicts one report per request;
// reports are compared field by field in order. Stimulus is a directed
// opcode walk followed by random small programs (load, switch, run) mixed
// with noise requests, under random idling on both channels.
// ----------------------------------------------------------------------------
package acpu_tb_pkg;
   import acpu_pkg::*;

   localparam logic [1:0]  OP_UNUSED           = 2'd3;
   localparam logic [31:0] OPC_HALT            = 32'd0;
   localparam logic [31:0] OPC_FIRST_UNDEFINED = 32'd13;
   localparam int          ENTRY_COUNT         = 256;

   typedef struct packed {
      logic [1:0]  operation;
      logic [7:0]  entry_address;
      logic [31:0] entry_first;
      logic [31:0] entry_second;
      logic [31:0] new_accumulator;
      logic [31:0] new_buffer;
      logic [31:0] new_data_address;
      logic [31:0] new_counter;
      logic [31:0] new_base;
      logic [31:0] new_opcode;
      logic [31:0] new_operand;
   } acpu_request;

   // shadow of the core state plus the reports still owed by the core
   class core_shadow;
      logic [31:0] acc_q, buf_q, mar_q, pc_q, base_q, opc_q, opd_q;
      logic [31:0] entry_first[ENTRY_COUNT];
      logic [31:0] entry_second[ENTRY_COUNT];
      rsp_type     owed_reports[$];
      int unsigned mismatches, checked;
      int unsigned loads, steps, halted_steps, switches, unused_ops;

      function new();
         acc_q = '0; buf_q = '0; mar_q = '0; pc_q = '0;
         base_q = '0; opc_q = '0; opd_q = '0;
         foreach (entry_first[i]) begin
            entry_first[i] = '0;
            entry_second[i] = '0;
         end
      endfunction

      function bit in_range(logic [31:0] a);
         return a < ENTRY_COUNT;
      endfunction

      function rsp_type snapshot();
         rsp_type s;
         s.running      = (opc_q != OPC_HALT);
         s.accumulator  = acc_q;
         s.buffer       = buf_q;
         s.data_address = mar_q;
         s.counter      = pc_q;
         s.base         = base_q;
         s.opcode       = opc_q;
         s.operand      = opd_q;
         return s;
      endfunction

      function void execute_step();
         logic [31:0] fetch_at;
         fetch_at = base_q + pc_q;
         if (in_range(fetch_at)) begin
            opc_q = entry_first[fetch_at[7:0]];
            opd_q = entry_second[fetch_at[7:0]];
         end else begin
            opc_q = OPC_HALT;
         end
         case (opc_q)
            OPC_ACC_FROM_OPD: acc_q = opd_q;
            OPC_ACC_FROM_BUF: acc_q = buf_q;
            OPC_ACC_FROM_MAR: acc_q = mar_q;
            OPC_BUF_FROM_ACC: buf_q = acc_q;
            OPC_MAR_FROM_ACC: mar_q = acc_q;
            OPC_MEM_READ: begin
               if (in_range(mar_q)) buf_q = entry_first[mar_q[7:0]];
               else opc_q = OPC_HALT;
            end
            OPC_MEM_WRITE: begin
               if (in_range(mar_q)) begin
                  entry_first[mar_q[7:0]] = buf_q;
                  entry_second[mar_q[7:0]] = '0;
               end else begin
                  opc_q = OPC_HALT;
               end
            end
            OPC_ADD: acc_q = acc_q + buf_q;
            OPC_MUL: acc_q = acc_q * buf_q;
            OPC_AND: acc_q = (acc_q != 0 && buf_q != 0) ? 32'd1 : 32'd0;
            OPC_OR:  acc_q = (acc_q != 0 || buf_q != 0) ? 32'd1 : 32'd0;
            OPC_JNZ: begin
               if (acc_q != 0) pc_q = opd_q - 32'd1;
            end
            default: ;
         endcase
         pc_q = pc_q + 32'd1;
      endfunction

      function void note_request(acpu_request r);
         rsp_type s;
         case (r.operation)
            OP_LOAD: begin
               entry_first[r.entry_address] = r.entry_first;
               entry_second[r.entry_address] = r.entry_second;
               loads++;
               s = snapshot();
            end
            OP_STEP: begin
               execute_step();
               steps++;
               s = snapshot();
               if (!s.running) halted_steps++;
            end
            OP_SWITCH: begin
               // old register set is reported, then replaced
               s = snapshot();
               acc_q  = r.new_accumulator;
               buf_q  = r.new_buffer;
               mar_q  = r.new_data_address;
               pc_q   = r.new_counter;
               base_q = r.new_base;
               opc_q  = r.new_opcode;
               opd_q  = r.new_operand;
               switches++;
            end
            default: begin
               s = snapshot();
               unused_ops++;
            end
         endcase
         owed_reports.push_back(s);
      endfunction

      function bit field_differs(string name, logic [31:0] want, logic [31:0] got);
         if (got === want) return 1'b0;
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
         return 1'b1;
      endfunction

      function void check_report(rsp_type got);
         rsp_type want;
         bit      bad;
         if (owed_reports.size() == 0) begin
            $display("%0t: unexpected report transfer, none owed", $time);
            mismatches++;
            return;
         end
         want = owed_reports.pop_front();
         checked++;
         bad = 1'b0;
         bad |= field_differs("running",      want.running,      got.running);
         bad |= field_differs("accumulator",  want.accumulator,  got.accumulator);
         bad |= field_differs("buffer",       want.buffer,       got.buffer);
         bad |= field_differs("data_address", want.data_address, got.data_address);
         bad |= field_differs("counter",      want.counter,      got.counter);
         bad |= field_differs("base",         want.base,         got.base);
         bad |= field_differs("opcode",       want.opcode,       got.opcode);
         bad |= field_differs("operand",      want.operand,      got.operand);
         if (bad) mismatches++;
      endfunction

      function int unsigned owed_count();
         return owed_reports.size();
      endfunction
   endclass

endpackage

module accumulator_cpu_core_top_tb;
   import acpu_pkg::*;
   import acpu_tb_pkg::*;

   localparam int TOTAL_REQUESTS  = 1850;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 20;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_operation;
   logic [7:0]         req_entry_address;
   logic signed [31:0] req_entry_first;
   logic signed [31:0] req_entry_second;
   logic signed [31:0] req_new_accumulator;
   logic signed [31:0] req_new_buffer;
   logic signed [31:0] req_new_data_address;
   logic signed [31:0] req_new_counter;
   logic signed [31:0] req_new_base;
   logic signed [31:0] req_new_opcode;
   logic signed [31:0] req_new_operand;
   logic               rsp_valid;
   logic               rsp_ready;
   logic               rsp_running;
   logic signed [31:0] rsp_accumulator;
   logic signed [31:0] rsp_buffer;
   logic signed [31:0] rsp_data_address;
   logic signed [31:0] rsp_counter;
   logic signed [31:0] rsp_base;
   logic signed [31:0] rsp_opcode;
   logic signed [31:0] rsp_operand;

   core_shadow  shadow = new();
   int unsigned requests_sent;
   int          send_gap_max;
   int          rsp_gap_max;
   int          rsp_stall_left;
   int          hold_cycles;

   accumulator_cpu_core_top u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_operation        (req_operation),
      .req_entry_address    (req_entry_address),
      .req_entry_first      (req_entry_first),
      .req_entry_second     (req_entry_second),
      .req_new_accumulator  (req_new_accumulator),
      .req_new_buffer       (req_new_buffer),
      .req_new_data_address (req_new_data_address),
      .req_new_counter      (req_new_counter),
      .req_new_base         (req_new_base),
      .req_new_opcode       (req_new_opcode),
      .req_new_operand      (req_new_operand),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_running          (rsp_running),
      .rsp_accumulator      (rsp_accumulator),
      .rsp_buffer           (rsp_buffer),
      .rsp_data_address     (rsp_data_address),
      .rsp_counter          (rsp_counter),
      .rsp_base             (rsp_base),
      .rsp_opcode           (rsp_opcode),
      .rsp_operand          (rsp_operand)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("accumulator_cpu_core_top_tb failed");
      $finish;
   end

   // receiver: per-transfer random stall, plus a long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      rsp_stall_left = 0;
      hold_cycles = 0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            hold_cycles--;
         end else if (rsp_stall_left > 0) begin
            rsp_ready <= 1'b0;
            rsp_stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         shadow.check_report({rsp_running, rsp_accumulator, rsp_buffer, rsp_data_address,
                              rsp_counter, rsp_base, rsp_opcode, rsp_operand});
         rsp_stall_left = $urandom_range(0, rsp_gap_max);
      end
   end

   // called at a falling edge; returns at a falling edge
   task automatic send_request(input acpu_request r);
      int gap;
      req_operation        <= r.operation;
      req_entry_address    <= r.entry_address;
      req_entry_first      <= r.entry_first;
      req_entry_second     <= r.entry_second;
      req_new_accumulator  <= r.new_accumulator;
      req_new_buffer       <= r.new_buffer;
      req_new_data_address <= r.new_data_address;
      req_new_counter      <= r.new_counter;
      req_new_base         <= r.new_base;
      req_new_opcode       <= r.new_opcode;
      req_new_operand      <= r.new_operand;
      req_valid            <= 1'b1;
      do @(posedge clock); while (req_ready !== 1'b1);
      shadow.note_request(r);
      requests_sent++;
      gap = $urandom_range(0, send_gap_max);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      if (req_valid) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      while (shadow.owed_count() != 0) @(negedge clock);
   endtask

   function automatic logic [31:0] random_word();
      case ($urandom_range(0, 7))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic acpu_request noise_request();
      acpu_request r;
      r.operation        = 2'($urandom_range(0, 3));
      r.entry_address    = 8'($urandom_range(0, 255));
      r.entry_first      = random_word();
      r.entry_second     = random_word();
      r.new_accumulator  = random_word();
      r.new_buffer       = random_word();
      r.new_data_address = random_word();
      r.new_counter      = random_word();
      r.new_base         = random_word();
      r.new_opcode       = random_word();
      r.new_operand      = random_word();
      return r;
   endfunction

   function automatic acpu_request load_request(logic [7:0] addr, logic [31:0] first,
                                                logic [31:0] second);
      acpu_request r;
      r = noise_request();
      r.operation     = OP_LOAD;
      r.entry_address = addr;
      r.entry_first   = first;
      r.entry_second  = second;
      return r;
   endfunction

   function automatic acpu_request step_request();
      acpu_request r;
      r = noise_request();
      r.operation = OP_STEP;
      return r;
   endfunction

   function automatic acpu_request switch_request(logic [31:0] acc, logic [31:0] bufv,
                                                  logic [31:0] mar, logic [31:0] pc,
                                                  logic [31:0] origin, logic [31:0] opc,
                                                  logic [31:0] opd);
      acpu_request r;
      r = noise_request();
      r.operation        = OP_SWITCH;
      r.new_accumulator  = acc;
      r.new_buffer       = bufv;
      r.new_data_address = mar;
      r.new_counter      = pc;
      r.new_base         = origin;
      r.new_opcode       = opc;
      r.new_operand      = opd;
      return r;
   endfunction

   // walks every opcode from reset state: wrap add/mul, logic ops,
   // bad-address store and load, taken jump, then a wrapped negative fetch
   task automatic run_directed();
      acpu_request r;
      send_request(load_request(8'd0,  OPC_ACC_FROM_OPD, 32'h7FFF_FFFF));
      send_request(load_request(8'd1,  OPC_BUF_FROM_ACC, 32'h8000_0000));
      send_request(load_request(8'd2,  OPC_ACC_FROM_OPD, 32'd1));
      send_request(load_request(8'd3,  OPC_ADD,          32'hFFFF_FFFF));
      send_request(load_request(8'd4,  OPC_MUL,          32'd0));
      send_request(load_request(8'd5,  OPC_AND,          32'd0));
      send_request(load_request(8'd6,  OPC_OR,           32'd0));
      send_request(load_request(8'd7,  OPC_ACC_FROM_BUF, 32'd0));
      send_request(load_request(8'd8,  OPC_MAR_FROM_ACC, 32'd0));
      send_request(load_request(8'd9,  OPC_ACC_FROM_MAR, 32'd0));
      send_request(load_request(8'd10, OPC_MEM_WRITE,    32'd0));
      send_request(load_request(8'd11, OPC_MEM_READ,     32'd0));
      send_request(load_request(8'd12, OPC_JNZ,          32'd0));
      repeat (13) send_request(step_request());
      send_request(switch_request(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                                  32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                                  32'h8000_0000));
      send_request(step_request());
      r = noise_request();
      r.operation = OP_UNUSED;
      send_request(r);
   endtask

   // loads a short random program, switches into it and runs it
   task automatic run_program();
      int          length;
      int          origin;
      int          pick;
      logic [31:0] opc;
      logic [31:0] opd;
      length = $urandom_range(3, 12);
      if ($urandom_range(0, 7) == 0) origin = $urandom_range(256 - length, 255);
      else origin = $urandom_range(0, 256 - length);
      for (int i = 0; i < length; i++) begin
         pick = $urandom_range(0, 19);
         if (pick < 12) opc = OPC_ACC_FROM_OPD + pick;
         else begin
            case (pick)
               12: opc = OPC_MEM_READ;
               13: opc = OPC_MEM_WRITE;
               14: opc = OPC_JNZ;
               15: opc = OPC_MAR_FROM_ACC;
               16: opc = OPC_HALT;
               17: opc = OPC_FIRST_UNDEFINED + $urandom_range(0, 3);
               default: opc = random_word();
            endcase
         end
         if (opc == OPC_JNZ) opd = $urandom_range(0, length);
         else if (opc == OPC_ACC_FROM_OPD && $urandom_range(0, 3) != 0)
            opd = $urandom_range(0, 260);
         else opd = random_word();
         send_request(load_request(8'(origin + i), opc, opd));
      end
      if ($urandom_range(0, 15) == 0) send_request(noise_request());
      send_request(switch_request(random_word(), random_word(),
                                  ($urandom_range(0, 3) == 0) ? random_word()
                                                              : $urandom_range(0, 255),
                                  32'd0, origin, random_word(), random_word()));
      repeat ($urandom_range(length, 2 * length + 4)) begin
         if ($urandom_range(0, 15) == 0) send_request(noise_request());
         else send_request(step_request());
      end
   endtask

   initial begin
      int phase;
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = OP_LOAD;
      req_entry_address = '0;
      req_entry_first = '0;
      req_entry_second = '0;
      req_new_accumulator = '0;
      req_new_buffer = '0;
      req_new_data_address = '0;
      req_new_counter = '0;
      req_new_base = '0;
      req_new_opcode = '0;
      req_new_operand = '0;
      requests_sent = 0;
      send_gap_max = 4;
      rsp_gap_max = 4;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();

      phase = 0;
      while (requests_sent < TOTAL_REQUESTS) begin
         case (phase % 5)
            0: begin send_gap_max = 0;  rsp_gap_max = 0;  end
            1: begin send_gap_max = 14; rsp_gap_max = 0;  end
            2: begin send_gap_max = 0;  rsp_gap_max = 14; end
            3: begin send_gap_max = 14; rsp_gap_max = 14; end
            default: begin send_gap_max = 3; rsp_gap_max = 3; end
         endcase
         // long receiver hold-off while requests keep coming back to back
         if (phase == 2) hold_cycles = HOLD_OFF_CYCLES;
         repeat (4) run_program();
         if (phase % 3 == 1) wait_drained();
         phase++;
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d loads, %0d steps (%0d halted), %0d switches, %0d unused ops",
               shadow.loads, shadow.steps, shadow.halted_steps, shadow.switches,
               shadow.unused_ops);
      $display("%0d reports checked, %0d bad", shadow.checked, shadow.mismatches);
      if (shadow.mismatches == 0) begin
         $display("accumulator_cpu_core_top_tb passed");
      end else begin
         $display("accumulator_cpu_core_top_tb failed");
      end
      $finish;
   end

endmodule

### sim.f
rtl/acpu_pkg.sv
rtl/acpu_rsp_fifo.sv
rtl/accumulator_cpu_core_top.sv
tb/accumulator_cpu_core_top_tb.sv
